/* rtl/hbs_pkg.sv */
// ----------------------------------------------------------------------------
// hbs_pkg: shared constants and types for the heightmap bilinear sampler
// Holds the grid sizing, the request codes and the register indexes.
// ----------------------------------------------------------------------------
package hbs_pkg;

  localparam int MAX_DIM     = 256;
  localparam int CELL_W      = $clog2(MAX_DIM);
  localparam int DIM_W       = CELL_W + 1;
  localparam int IDX_W       = 2 * CELL_W;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int SAMPLE_W    = 16;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [1:0] {
    CFG_GRID_DIM       = 2'd0,
    CFG_INV_SCALE_X    = 2'd1,
    CFG_INV_SCALE_Z    = 2'd2,
    CFG_VERTICAL_SCALE = 2'd3
  } cfg_index_t;

endpackage

/* rtl/hbs_ram.sv */
// ----------------------------------------------------------------------------
// hbs_ram: generic RAM, one write port and two registered read ports
// Read data updates only on cycles with the read enable high.
// ----------------------------------------------------------------------------
module hbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

/* rtl/heightmap_bilinear_sampler.sv */
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler: bilinear height lookup on a square grid
// A query result passes stages 1 to 8 and then the output register.
// Throughput: one beat per cycle while no output stall holds the pipe, set by
// eight stages and two RAM copies, each reading two grid corners per cycle.
// Reset: control state, has_samples and the registers return to defaults;
// the grid RAM is not cleared and holds undefined data until loaded.
// ----------------------------------------------------------------------------
module heightmap_bilinear_sampler
  import hbs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               req_type,
  input  logic [15:0]        load_index,
  input  logic signed [15:0] load_height,
  input  logic signed [23:0] query_x,
  input  logic signed [23:0] query_z,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] height,
  // register write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  // --------------------------------------------------------------------------
  // Registers and the loaded flag
  // --------------------------------------------------------------------------
  logic [DIM_W-1:0] grid_dim;
  logic [23:0]      inv_scale_x;
  logic [23:0]      inv_scale_z;
  logic [15:0]      vertical_scale;
  logic             has_samples;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_dim       <= '0;
      inv_scale_x    <= 24'd65536;
      inv_scale_z    <= 24'd65536;
      vertical_scale <= 16'd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_GRID_DIM:       grid_dim       <= cfg_data[DIM_W-1:0];
        CFG_INV_SCALE_X:    inv_scale_x    <= cfg_data;
        CFG_INV_SCALE_Z:    inv_scale_z    <= cfg_data;
        CFG_VERTICAL_SCALE: vertical_scale <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: the whole pipe advances unless a result is held
  // at the output by a stall. Bubbles move along like items.
  // --------------------------------------------------------------------------
  logic en;
  logic acc;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign acc      = in_valid && en;

  // Any load beat marks the grid as populated; loads always fall inside
  // the store since the index is exactly as wide as its address.
  always_ff @(posedge clk) begin
    if (rst) begin
      has_samples <= 1'b0;
    end else if (acc && req_type == REQ_LOAD) begin
      has_samples <= 1'b1;
    end
  end

  // Grid side length with anything past MAX_DIM folded to MAX_DIM.
  logic [DIM_W-1:0] dim_eff;
  assign dim_eff = (grid_dim > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : grid_dim;

  // --------------------------------------------------------------------------
  // Stage 1: capture the beat, decide whether the grid is empty
  // --------------------------------------------------------------------------
  logic               v1, q1, empty1;
  logic [DIM_W-1:0]   dim1;
  logic [IDX_W-1:0]   li1;
  logic [15:0]        lh1;
  logic signed [23:0] qx1, qz1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1     <= (req_type == REQ_QUERY);
      empty1 <= (dim_eff == '0) || !has_samples;
      dim1   <= dim_eff;
      li1    <= load_index[IDX_W-1:0];
      lh1    <= load_height;
      qx1    <= query_x;
      qz1    <= query_z;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: scale world coordinates into grid space (Q24.24)
  // --------------------------------------------------------------------------
  logic               v2, q2, empty2;
  logic [DIM_W-1:0]   dim2;
  logic [IDX_W-1:0]   li2;
  logic [15:0]        lh2;
  logic signed [48:0] px2, pz2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q2     <= q1;
      empty2 <= empty1;
      dim2   <= dim1;
      li2    <= li1;
      lh2    <= lh1;
      px2    <= qx1 * $signed({1'b0, inv_scale_x});
      pz2    <= qz1 * $signed({1'b0, inv_scale_z});
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: clamp to the grid, split into cell and fraction, find the
  // neighbour cell (held at the last row or column)
  // --------------------------------------------------------------------------
  function automatic logic [IDX_W-1:0] grid_coord(input logic signed [48:0] p,
                                                  input logic [DIM_W-1:0]   d);
    logic [DIM_W-1:0] dm1;
    logic [32:0]      s;
    logic [32:0]      lim;
    begin
      dm1 = d - DIM_W'(1);
      s   = p[48:16];
      lim = 33'({dm1[CELL_W-1:0], 8'h00});
      if (p <= 0) begin
        grid_coord = '0;
      end else if (s > lim) begin
        grid_coord = lim[IDX_W-1:0];
      end else begin
        grid_coord = s[IDX_W-1:0];
      end
    end
  endfunction

  function automatic logic [CELL_W-1:0] next_cell(input logic [CELL_W-1:0] c,
                                                  input logic [DIM_W-1:0]  d);
    logic [DIM_W-1:0] cp1;
    logic [DIM_W-1:0] dm1;
    begin
      cp1 = {1'b0, c} + DIM_W'(1);
      dm1 = d - DIM_W'(1);
      next_cell = (cp1 < d) ? cp1[CELL_W-1:0] : dm1[CELL_W-1:0];
    end
  endfunction

  logic [IDX_W-1:0] cx, cz;
  assign cx = grid_coord(px2, dim2);
  assign cz = grid_coord(pz2, dim2);

  logic              v3, q3, empty3;
  logic [DIM_W-1:0]  dim3;
  logic [IDX_W-1:0]  li3;
  logic [15:0]       lh3;
  logic [CELL_W-1:0] x0_3, x1_3, z0_3, z1_3;
  logic [7:0]        tx3, tz3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q3     <= q2;
      empty3 <= empty2;
      dim3   <= dim2;
      li3    <= li2;
      lh3    <= lh2;
      x0_3   <= cx[IDX_W-1:8];
      z0_3   <= cz[IDX_W-1:8];
      x1_3   <= next_cell(cx[IDX_W-1:8], dim2);
      z1_3   <= next_cell(cz[IDX_W-1:8], dim2);
      tx3    <= cx[7:0];
      tz3    <= cz[7:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: row base addresses z*dim
  // --------------------------------------------------------------------------
  logic [IDX_W-1:0] zw0, zw1, dw3;
  assign zw0 = IDX_W'(z0_3);
  assign zw1 = IDX_W'(z1_3);
  assign dw3 = IDX_W'(dim3);

  logic              v4, q4, empty4;
  logic [IDX_W-1:0]  li4;
  logic [15:0]       lh4;
  logic [IDX_W-1:0]  zb0_4, zb1_4;
  logic [CELL_W-1:0] x0_4, x1_4;
  logic [7:0]        tx4, tz4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q4     <= q3;
      empty4 <= empty3;
      li4    <= li3;
      lh4    <= lh3;
      zb0_4  <= zw0 * dw3;
      zb1_4  <= zw1 * dw3;
      x0_4   <= x0_3;
      x1_4   <= x1_3;
      tx4    <= tx3;
      tz4    <= tz3;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: grid RAM access. Loads write here too, so every query sees
  // exactly the loads accepted before it. Two copies give four reads.
  // --------------------------------------------------------------------------
  logic [IDX_W-1:0]    a00, a01, a10, a11;
  logic                ram_we;
  logic [SAMPLE_W-1:0] r00, r01, r10, r11;

  assign a00    = zb0_4 + IDX_W'(x0_4);
  assign a01    = zb0_4 + IDX_W'(x1_4);
  assign a10    = zb1_4 + IDX_W'(x0_4);
  assign a11    = zb1_4 + IDX_W'(x1_4);
  assign ram_we = en && v4 && !q4;

  hbs_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (STORE_DEPTH)
  ) u_ram_row0 (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (li4),
    .wdata   (lh4),
    .re      (en),
    .raddr_a (a00),
    .raddr_b (a01),
    .rdata_a (r00),
    .rdata_b (r01)
  );

  hbs_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (STORE_DEPTH)
  ) u_ram_row1 (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (li4),
    .wdata   (lh4),
    .re      (en),
    .raddr_a (a10),
    .raddr_b (a11),
    .rdata_a (r10),
    .rdata_b (r11)
  );

  logic       v5, q5, empty5;
  logic [7:0] tx5, tz5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q5     <= q4;
      empty5 <= empty4;
      tx5    <= tx4;
      tz5    <= tz4;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: lerp along x, a*(256-tx) + b*tx (Q17.8)
  // --------------------------------------------------------------------------
  logic [8:0] wx0, wx1;
  assign wx0 = 9'd256 - {1'b0, tx5};
  assign wx1 = {1'b0, tx5};

  logic               v6, q6, empty6;
  logic [7:0]         tz6;
  logic signed [25:0] hx0_6, hx1_6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q6     <= q5;
      empty6 <= empty5;
      tz6    <= tz5;
      hx0_6  <= $signed(r00) * $signed({1'b0, wx0}) + $signed(r01) * $signed({1'b0, wx1});
      hx1_6  <= $signed(r10) * $signed({1'b0, wx0}) + $signed(r11) * $signed({1'b0, wx1});
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: lerp along z (Q17.16)
  // --------------------------------------------------------------------------
  logic [8:0] wz0, wz1;
  assign wz0 = 9'd256 - {1'b0, tz6};
  assign wz1 = {1'b0, tz6};

  logic               v7, q7, empty7;
  logic signed [33:0] h7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q7     <= q6;
      empty7 <= empty6;
      h7     <= hx0_6 * $signed({1'b0, wz0}) + hx1_6 * $signed({1'b0, wz1});
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: vertical scale (Q26.24)
  // --------------------------------------------------------------------------
  logic               v8, q8, empty8;
  logic signed [50:0] vp8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q8     <= q7;
      empty8 <= empty7;
      vp8    <= h7 * $signed({1'b0, vertical_scale});
    end
  end

  // --------------------------------------------------------------------------
  // Output register: round to Q23.8, saturate, zero empty-grid results, drop load beats
  // --------------------------------------------------------------------------
  logic signed [50:0] vr;
  logic signed [34:0] vs;
  logic signed [31:0] vsat;

  assign vr = vp8 + 51'sd32768;
  assign vs = vr[50:16];

  always_comb begin
    if (vs[34:31] == 4'b0000 || vs[34:31] == 4'b1111) begin
      vsat = vs[31:0];
    end else if (vs[34]) begin
      vsat = 32'sh8000_0000;
    end else begin
      vsat = 32'sh7FFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v8 && q8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      height <= empty8 ? '0 : vsat;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A load beat leaving the pipe never turns into a result.
  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (en && v8 && !q8) |=> !out_valid)
    else $error("load beat produced a result");

  // Once loaded, the grid stays marked as populated until reset.
  a_samples_sticky: assert property (@(posedge clk) disable iff (rst)
    has_samples |=> has_samples)
    else $error("has_samples dropped without reset");

  // A frozen pipe keeps its last stage in place.
  a_freeze_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(v8) && $stable(q8)))
    else $error("pipeline moved while frozen");

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for heightmap_bilinear_sampler
// Loads grid samples and sends height queries under several register
// settings and idle patterns. Every query is predicted in the bench, and
// each result beat is compared in order against the predicted heights.
// ----------------------------------------------------------------------------
module testbench
  import hbs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               req_type = REQ_LOAD;
  logic [15:0]        load_index = '0;
  logic signed [15:0] load_height = '0;
  logic signed [23:0] query_x = '0;
  logic signed [23:0] query_z = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] height;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = CFG_GRID_DIM;
  logic [23:0]        cfg_data = '0;

  heightmap_bilinear_sampler u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
    .load_index(load_index), .load_height(load_height),
    .query_x(query_x), .query_z(query_z),
    .out_valid(out_valid), .out_stall(out_stall), .height(height),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Local copy of the sampler's state and registers.
  logic [15:0] grid_heights [STORE_DEPTH];
  bit          grid_written [STORE_DEPTH];
  bit          any_loaded;
  int unsigned dim_reg;
  int unsigned inv_x_reg;
  int unsigned inv_z_reg;
  int unsigned vscale_reg;

  logic signed [31:0] pending_heights [$];
  int mismatches;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // Effective grid side: oversized settings fold down to the full grid.
  function automatic int unsigned eff_dim();
    return (dim_reg > MAX_DIM) ? MAX_DIM : dim_reg;
  endfunction

  // Scale a world coordinate into a clamped Q.8 grid position.
  function automatic int unsigned grid_pos(logic signed [23:0] w, int unsigned inv,
                                           int unsigned dim);
    longint p;
    longint lim;
    longint s;
    p   = longint'(w) * longint'(inv);
    lim = longint'(dim - 1) << 8;
    if (p <= 0) return 0;
    s = p >>> 16;
    return (s > lim) ? 32'(lim) : 32'(s);
  endfunction

  // Row-major indexes of the four corners around a query: x0z0 x1z0 x0z1 x1z1.
  function automatic void corner_indexes(logic signed [23:0] qx, logic signed [23:0] qz,
                                         output int unsigned idx [4]);
    int unsigned dim;
    int unsigned cx;
    int unsigned cz;
    int unsigned x0;
    int unsigned x1;
    int unsigned z0;
    int unsigned z1;
    dim = eff_dim();
    cx = grid_pos(qx, inv_x_reg, dim);
    cz = grid_pos(qz, inv_z_reg, dim);
    x0 = cx >> 8;
    z0 = cz >> 8;
    x1 = (x0 + 1 < dim) ? x0 + 1 : dim - 1;
    z1 = (z0 + 1 < dim) ? z0 + 1 : dim - 1;
    idx[0] = z0 * dim + x0;
    idx[1] = z0 * dim + x1;
    idx[2] = z1 * dim + x0;
    idx[3] = z1 * dim + x1;
  endfunction

  function automatic logic signed [31:0] predict_height(logic signed [23:0] qx,
                                                       logic signed [23:0] qz);
    int unsigned dim;
    int unsigned idx [4];
    longint tx;
    longint tz;
    longint c [4];
    longint row0;
    longint row1;
    longint v;
    dim = eff_dim();
    if (dim == 0 || !any_loaded) return '0;
    corner_indexes(qx, qz, idx);
    tx = grid_pos(qx, inv_x_reg, dim) & 8'hFF;
    tz = grid_pos(qz, inv_z_reg, dim) & 8'hFF;
    foreach (idx[i]) c[i] = longint'($signed(grid_heights[idx[i]]));
    row0 = c[0] * (256 - tx) + c[1] * tx;
    row1 = c[2] * (256 - tx) + c[3] * tx;
    v = ((row0 * (256 - tz) + row1 * tz) * longint'(vscale_reg) + 32768) >>> 16;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // Receiver: stall at random, or hold off for a whole counted stretch.
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Result checker: each accepted beat against the oldest predicted height.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_heights.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: height %0d", height);
      end else begin
        if (height !== pending_heights[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("height mismatch: expected %0d actual %0d",
                     pending_heights[0], height);
        end
        void'(pending_heights.pop_front());
      end
    end
  end

  // Offer one request beat, hold it until taken, then predict and maybe idle.
  task automatic send_beat(logic rt, logic [15:0] li, logic signed [15:0] lh,
                           logic signed [23:0] qx, logic signed [23:0] qz);
    req_type    <= rt;
    load_index  <= li;
    load_height <= lh;
    query_x     <= qx;
    query_z     <= qz;
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (rt == REQ_LOAD) begin
      grid_heights[li] = lh;
      grid_written[li] = 1'b1;
      any_loaded = 1'b1;
    end else begin
      pending_heights.push_back(predict_height(qx, qz));
    end
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic load_sample(int unsigned idx, logic signed [15:0] h);
    send_beat(REQ_LOAD, idx[15:0], h, 24'($urandom), 24'($urandom));
  endtask

  // Query, first loading any corner that has never been written.
  task automatic query(logic signed [23:0] qx, logic signed [23:0] qz);
    int unsigned idx [4];
    if (eff_dim() != 0) begin
      corner_indexes(qx, qz, idx);
      foreach (idx[i])
        if (!grid_written[idx[i]]) load_sample(idx[i], 16'($urandom));
    end
    send_beat(REQ_QUERY, 16'($urandom), 16'($urandom), qx, qz);
  endtask

  // Drop valid and wait out every outstanding result plus the pipeline depth.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t ri, int unsigned value);
    drain();
    cfg_index <= ri;
    cfg_data  <= value[23:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (ri)
      CFG_GRID_DIM:       dim_reg    = value & 9'h1FF;
      CFG_INV_SCALE_X:    inv_x_reg  = value & 24'hFFFFFF;
      CFG_INV_SCALE_Z:    inv_z_reg  = value & 24'hFFFFFF;
      CFG_VERTICAL_SCALE: vscale_reg = value & 16'hFFFF;
      default: ;
    endcase
  endtask

  // The first and last queries, before any load and on a zero-sized grid, read zero.
  task automatic test_empty_grid();
    query(24'sh000100, 24'sh000100);
    write_reg(CFG_GRID_DIM, 4);
    query(24'sh000180, 24'sh000080);
    write_reg(CFG_GRID_DIM, 0);
    load_sample(0, 16'sh1234);
    query(24'sh7FFFFF, 24'sh800000);
  endtask

  // Extreme heights, coordinates and register values on tiny grids and the full grid.
  task automatic test_corner_cases();
    write_reg(CFG_GRID_DIM, 2);
    load_sample(0, 16'sh7FFF);
    load_sample(1, -16'sh8000);
    load_sample(2, 16'sh0000);
    load_sample(3, 16'sh0001);
    query(24'sh000000, 24'sh000000);
    query(24'sh000080, 24'sh000040);
    query(24'sh0000FF, 24'sh0000FF);
    query(24'sh800000, 24'sh800000);    // negative clamps to cell 0
    query(24'sh7FFFFF, 24'sh7FFFFF);    // far edge clamps to dim-1
    write_reg(CFG_VERTICAL_SCALE, 16'hFFFF);
    query(24'sh000000, 24'sh000000);
    query(24'sh000000, 24'sh0000FF);
    write_reg(CFG_VERTICAL_SCALE, 0);
    query(24'sh000040, 24'sh000040);
    write_reg(CFG_INV_SCALE_X, 24'hFFFFFF);
    write_reg(CFG_INV_SCALE_Z, 0);
    query(24'sh000001, 24'sh7FFFFF);
    write_reg(CFG_VERTICAL_SCALE, 256);
    write_reg(CFG_GRID_DIM, 1);         // neighbour folds onto the single cell
    query(24'sh000080, 24'sh000080);
    write_reg(CFG_GRID_DIM, 9'h1FF);    // oversized side acts as the full grid
    write_reg(CFG_INV_SCALE_X, 65536);
    write_reg(CFG_INV_SCALE_Z, 65536);
    query(24'sh7FFFFF, 24'sh7FFFFF);
    query(24'sh00FE80, 24'sh000040);
  endtask

  function automatic logic signed [23:0] pick_coord(int unsigned dim);
    case ($urandom_range(9))
      0: return 24'($urandom);
      1: return -$signed({1'b0, 23'($urandom_range(0, 4096))});
      default: return 24'($urandom_range(0, (dim + 1) * 256));
    endcase
  endfunction

  task automatic randomise_regs();
    int unsigned d;
    case ($urandom_range(9))
      0: d = 0;
      1: d = MAX_DIM;
      2: d = $urandom_range(257, 511);
      3: d = 1;
      default: d = $urandom_range(2, 16);
    endcase
    write_reg(CFG_GRID_DIM, d);
    for (int i = 0; i < 2; i++)
      case ($urandom_range(5))
        0: write_reg(i ? CFG_INV_SCALE_Z : CFG_INV_SCALE_X, 0);
        1: write_reg(i ? CFG_INV_SCALE_Z : CFG_INV_SCALE_X, 24'hFFFFFF);
        2: write_reg(i ? CFG_INV_SCALE_Z : CFG_INV_SCALE_X, $urandom_range(4096, 262144));
        default: write_reg(i ? CFG_INV_SCALE_Z : CFG_INV_SCALE_X, 65536);
      endcase
    write_reg(CFG_VERTICAL_SCALE, $urandom_range(3) ? $urandom_range(0, 1024) : $urandom);
  endtask

  // Mixed loads and queries; regs change every 60 iterations, only when idle.
  task automatic test_random_traffic(int n, bit with_pressure);
    int unsigned dim;
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) randomise_regs();
      if (with_pressure && i == 40) hold_reqs++;        // fill the pipe
      if (with_pressure && i == 150) drain();           // sender pauses
      dim = (eff_dim() == 0) ? 1 : eff_dim();
      if ($urandom_range(99) < 35) begin
        if ($urandom_range(3) == 0) load_sample($urandom, 16'($urandom));
        else load_sample($urandom_range(0, dim * dim - 1), 16'($urandom));
      end else begin
        query(pick_coord(dim), pick_coord(dim));
      end
    end
  endtask

  initial begin
    dim_reg = 0;
    inv_x_reg = 65536;
    inv_z_reg = 65536;
    vscale_reg = 256;
    any_loaded = 1'b0;
    mismatches = 0;
    send_idle_pct = 16;
    recv_idle_pct = 86;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_empty_grid();
    test_corner_cases();
    test_random_traffic(300, 1'b0);
    send_idle_pct = 86;
    recv_idle_pct = 16;
    test_random_traffic(300, 1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(300, 1'b1);
    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_heights.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
